@@ rtl/pce_pkg.sv @@
// ----------------------------------------------------------------------------
// pce_pkg
// Shared widths, register indexes, settings types and helpers for the
// palette color effects pipeline.
// ----------------------------------------------------------------------------
package pce_pkg;

	localparam int CH_W       = 8;
	localparam int TINT_W     = 16;
	localparam int MUL_W      = TINT_W + 2;
	localparam int OFF_W      = 11;
	localparam int FADE_W     = 17;
	localparam int MASK_W     = 3;
	localparam int PROD_W     = CH_W + 1 + MUL_W;
	localparam int TINT_FRAC  = 13;
	localparam int Q_W        = PROD_W - TINT_FRAC;
	localparam int CLAMP_W    = 16;
	localparam int FPROD_W    = CH_W + FADE_W - 1;
	localparam int NSTAGE     = 5;
	localparam int NUM_CH     = 3;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 17;

	localparam logic [CFG_IDX_W-1:0] REG_FILTER_MASK  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_TINT_RED     = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_TINT_GREEN   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_TINT_BLUE    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_OFFSET_RED   = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_OFFSET_GREEN = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_OFFSET_BLUE  = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_FADE_FACTOR  = 3'd7;

	localparam logic [FADE_W-1:0] FADE_ONE = 17'h10000;

	// per-channel settings as seen by the datapath
	typedef struct packed {
		logic                    dim;
		logic signed [MUL_W-1:0] mul;
		logic signed [OFF_W-1:0] off;
		logic                    fade_on;
		logic [FADE_W-2:0]       fade;
	} pce_chan_cfg_t;

	// bit 0 moves stage 1, bit NSTAGE-1 moves the output stage
	typedef logic [NSTAGE-1:0] pce_stage_en_t;

	typedef struct packed {
		logic [CH_W-1:0] index;
		logic            last;
	} pce_meta_t;

	function automatic logic [CH_W-1:0] clamp_u8(input logic signed [CLAMP_W-1:0] v);
		logic [CH_W-1:0] r;
		if (v < 0) begin
			r = '0;
		end else if (v > $signed(CLAMP_W'(255))) begin
			r = '1;
		end else begin
			r = v[CH_W-1:0];
		end
		return r;
	endfunction

endpackage

@@ rtl/palette_color_effects.sv @@
// ----------------------------------------------------------------------------
// palette_color_effects
// Recolors streamed RGB palette entries: filter, tint, offset and fade.
// ----------------------------------------------------------------------------
// Takes one palette entry per clock while results leave the output, and
// returns each after the five-stage channel datapath (filter, tint
// multiply, tint clamp, offset clamp, fade multiply), which every entry
// crosses once. Each stage holds under back-pressure only while it is
// occupied, so bubbles are squeezed out and the input keeps taking entries
// while a result waits at the output, until every stage is full. Entry
// index and last flag travel alongside unchanged. Write settings only while
// the pipeline is empty; a write takes effect for entries accepted from the
// next cycle on.
// ----------------------------------------------------------------------------
module palette_color_effects import pce_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	// settings write port
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	// palette entries in
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [31:0]           s_tdata,   // red_in, green_in, blue_in, entry_index
	input  logic                  s_tlast,   // last_entry
	// recolored entries out
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [31:0]           m_tdata,   // red_out, green_out, blue_out, index_out
	output logic                  m_tlast    // last_out
);

	pce_chan_cfg_t chan_cfg [NUM_CH];
	pce_stage_en_t en;
	logic [NSTAGE-1:0] valid_s;
	pce_meta_t         meta_s [NSTAGE];
	logic [CH_W-1:0]   c_res  [NUM_CH];

	pce_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.chan_cfg  (chan_cfg)
	);

	// A stage advances when it is empty or the stage after it advances.
	always_comb begin
		en[NSTAGE-1] = !valid_s[NSTAGE-1] || m_tready;
		for (int k = NSTAGE - 2; k >= 0; k--) begin
			en[k] = !valid_s[k] || en[k+1];
		end
	end

	assign s_tready = en[0];

	// Valid bits: each stage takes its upstream's valid when it advances.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s <= '0;
		end else begin
			if (en[0]) valid_s[0] <= s_tvalid;
			for (int k = 1; k < NSTAGE; k++) begin
				if (en[k]) valid_s[k] <= valid_s[k-1];
			end
		end
	end

	// Carry index and last flag down the pipe beside the channel data.
	always_ff @(posedge clk) begin
		if (en[0]) begin
			meta_s[0].index <= s_tdata[31:24];
			meta_s[0].last  <= s_tlast;
		end
		for (int k = 1; k < NSTAGE; k++) begin
			if (en[k]) meta_s[k] <= meta_s[k-1];
		end
	end

	// One datapath lane per color channel.
	for (genvar i = 0; i < NUM_CH; i++) begin : g_chan
		pce_chan u_chan (
			.clk   (clk),
			.en    (en),
			.cfg   (chan_cfg[i]),
			.c_in  (s_tdata[i*CH_W +: CH_W]),
			.c_out (c_res[i])
		);
	end

	assign m_tvalid = valid_s[NSTAGE-1];
	assign m_tdata  = {meta_s[NSTAGE-1].index, c_res[2], c_res[1], c_res[0]};
	assign m_tlast  = meta_s[NSTAGE-1].last;

endmodule

@@ rtl/pce_cfg.sv @@
// ----------------------------------------------------------------------------
// pce_cfg
// Settings registers and per-channel derived settings (dim flag, tint
// multiplier, offset, fade).
// ----------------------------------------------------------------------------
module pce_cfg import pce_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output pce_chan_cfg_t         chan_cfg [NUM_CH]
);

	logic        [MASK_W-1:0] mask_q;
	logic signed [TINT_W-1:0] tint_q [NUM_CH];
	logic signed [OFF_W-1:0]  off_q  [NUM_CH];
	logic        [FADE_W-1:0] fade_q;
	logic signed [MUL_W-1:0]  mul_q  [NUM_CH];
	logic signed [MUL_W-1:0]  t_ext  [NUM_CH];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_q <= '0;
			fade_q <= FADE_ONE;
			for (int i = 0; i < NUM_CH; i++) begin
				tint_q[i] <= '0;
				off_q[i]  <= '0;
			end
		end else if (cfg_we) begin
			case (cfg_index)
				REG_FILTER_MASK:  mask_q    <= cfg_data[MASK_W-1:0];
				REG_TINT_RED:     tint_q[0] <= cfg_data[TINT_W-1:0];
				REG_TINT_GREEN:   tint_q[1] <= cfg_data[TINT_W-1:0];
				REG_TINT_BLUE:    tint_q[2] <= cfg_data[TINT_W-1:0];
				REG_OFFSET_RED:   off_q[0]  <= cfg_data[OFF_W-1:0];
				REG_OFFSET_GREEN: off_q[1]  <= cfg_data[OFF_W-1:0];
				REG_OFFSET_BLUE:  off_q[2]  <= cfg_data[OFF_W-1:0];
				REG_FADE_FACTOR:  fade_q    <= cfg_data[FADE_W-1:0];
				default:          mask_q    <= mask_q;
			endcase
		end
	end

	always_comb begin
		for (int i = 0; i < NUM_CH; i++) begin
			t_ext[i] = {{(MUL_W-TINT_W){tint_q[i][TINT_W-1]}}, tint_q[i]};
		end
	end

	// multiplier is first used one stage after entry, so a register here is safe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_CH; i++) begin
				mul_q[i] <= '0;
			end
		end else begin
			mul_q[0] <= (t_ext[0] <<< 1) - t_ext[1] - t_ext[2];
			mul_q[1] <= (t_ext[1] <<< 1) - t_ext[0] - t_ext[2];
			mul_q[2] <= (t_ext[2] <<< 1) - t_ext[0] - t_ext[1];
		end
	end

	always_comb begin
		for (int i = 0; i < NUM_CH; i++) begin
			chan_cfg[i].dim     = (mask_q != '0) && !mask_q[i];
			chan_cfg[i].mul     = mul_q[i];
			chan_cfg[i].off     = off_q[i];
			chan_cfg[i].fade_on = !fade_q[FADE_W-1];
			chan_cfg[i].fade    = fade_q[FADE_W-2:0];
		end
	end

endmodule

@@ rtl/pce_chan.sv @@
// ----------------------------------------------------------------------------
// pce_chan
// One color channel through five stages: filter, tint product, tint clamp,
// offset clamp, fade.
// ----------------------------------------------------------------------------
module pce_chan import pce_pkg::*; (
	input  logic            clk,
	input  pce_stage_en_t   en,
	input  pce_chan_cfg_t   cfg,
	input  logic [CH_W-1:0] c_in,
	output logic [CH_W-1:0] c_out
);

	localparam logic signed [PROD_W-1:0] TINT_HALF = PROD_W'(1 << (TINT_FRAC - 1));
	localparam logic signed [PROD_W-1:0] TINT_BIAS = PROD_W'((1 << TINT_FRAC) - 1);
	localparam logic [FPROD_W-1:0]       FADE_HALF = FPROD_W'(1 << (FADE_W - 2));

	logic        [CH_W-1:0]    c_s1, c_s2, t_s3, a_s4, f_s5;
	logic signed [PROD_W-1:0]  prod_s2;

	logic signed [PROD_W-1:0]  c_ext, m_ext, prod, biased, shifted;
	logic signed [Q_W-1:0]     q;
	logic signed [CLAMP_W-1:0] tint_sum, off_sum;
	logic [FPROD_W-1:0]        fprod;

	always_comb begin
		c_ext    = {{(PROD_W-CH_W){1'b0}}, c_s1};
		m_ext    = {{(PROD_W-MUL_W){cfg.mul[MUL_W-1]}}, cfg.mul};
		prod     = c_ext * m_ext + TINT_HALF;
		// truncate toward zero: bias negative products before the shift
		biased   = prod_s2 + (prod_s2[PROD_W-1] ? TINT_BIAS : '0);
		shifted  = biased >>> TINT_FRAC;
		q        = shifted[Q_W-1:0];
		tint_sum = {{(CLAMP_W-CH_W){1'b0}}, c_s2} + {{(CLAMP_W-Q_W){q[Q_W-1]}}, q};
		off_sum  = {{(CLAMP_W-CH_W){1'b0}}, t_s3}
			+ {{(CLAMP_W-OFF_W){cfg.off[OFF_W-1]}}, cfg.off};
		fprod    = {{(FPROD_W-CH_W){1'b0}}, a_s4} * {{(FPROD_W-FADE_W+1){1'b0}}, cfg.fade}
			+ FADE_HALF;
	end

	always_ff @(posedge clk) begin
		if (en[0]) c_s1 <= cfg.dim ? (c_in >> 2) : c_in;
		if (en[1]) begin
			prod_s2 <= prod;
			c_s2    <= c_s1;
		end
		if (en[2]) t_s3 <= clamp_u8(tint_sum);
		if (en[3]) a_s4 <= clamp_u8(off_sum);
		if (en[4]) f_s5 <= cfg.fade_on ? fprod[FPROD_W-1:FPROD_W-CH_W] : a_s4;
	end

	assign c_out = f_s5;

endmodule

@@ tb/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the palette color effects pipeline.
// ----------------------------------------------------------------------------
// Streams palette entries through the block under several register settings.
// A directed table runs first. It covers reset values, channel extremes,
// every mask, tint, offset and fade stage, and fade values at and above one.
// Random phases follow, each with fresh settings and random entries. Every
// accepted entry is queued with colors from its row or an in-bench model.
// Each result transfer is checked field by field against the oldest queued
// entry. Both stream sides idle at random, and once the output holds off
// for a long stretch so the pipeline fills and stalls its input.
// ----------------------------------------------------------------------------
module tb;
	import pce_pkg::*;

	localparam int  RAND_ITEMS   = 1350;
	localparam int  HOLD_CYCLES  = 300;
	localparam int  TAIL_CYCLES  = 20;
	localparam int  CYCLE_LIMIT  = 400000;
	localparam int  PRESS_PHASE  = 3;
	localparam longint TINT_HALF = 4096;
	localparam longint TINT_DIV  = 8192;
	localparam longint FADE_HALF = 32768;

	// one palette entry, used for stimulus and for predicted results alike
	typedef struct packed {
		logic [CH_W-1:0] red;
		logic [CH_W-1:0] green;
		logic [CH_W-1:0] blue;
		logic [CH_W-1:0] index;
		logic            last;
	} entry_t;

	// register presets used by the directed table
	typedef enum logic [3:0] {
		DS_RESET, DS_MASK_ALL, DS_MASK_RED, DS_MASK_BLUE,
		DS_TINT_MAX, DS_TINT_MIN, DS_TINT_MIX,
		DS_OFF_MAX, DS_OFF_MIN, DS_OFF_MIX,
		DS_FADE_ZERO, DS_FADE_HALF, DS_FADE_OVER, DS_FADE_MAX
	} preset_e;

	typedef struct packed {
		preset_e         preset;
		logic [CH_W-1:0] red;
		logic [CH_W-1:0] green;
		logic [CH_W-1:0] blue;
		logic [CH_W-1:0] index;
		logic            last;
		logic            typed;     // expected colors below are given outright
		logic [CH_W-1:0] exp_red;
		logic [CH_W-1:0] exp_green;
		logic [CH_W-1:0] exp_blue;
	} dir_row_t;

	localparam int DIR_ROWS = 23;

	// rows with typed = 0 go to the color model
	dir_row_t directed_rows [DIR_ROWS] = '{
		'{DS_RESET,     8'd0,   8'd0,   8'd0,   8'd0,   1'b0, 1'b1, 8'd0,   8'd0,   8'd0},
		'{DS_RESET,     8'd255, 8'd255, 8'd255, 8'd255, 1'b1, 1'b1, 8'd255, 8'd255, 8'd255},
		'{DS_RESET,     8'd170, 8'd85,  8'd1,   8'h55,  1'b0, 1'b1, 8'd170, 8'd85,  8'd1},
		'{DS_RESET,     8'd85,  8'd170, 8'd254, 8'hAA,  1'b1, 1'b1, 8'd85,  8'd170, 8'd254},
		'{DS_MASK_ALL,  8'd255, 8'd128, 8'd3,   8'd1,   1'b0, 1'b1, 8'd255, 8'd128, 8'd3},
		'{DS_MASK_RED,  8'd255, 8'd255, 8'd255, 8'd2,   1'b0, 1'b1, 8'd255, 8'd63,  8'd63},
		'{DS_MASK_RED,  8'd3,   8'd4,   8'd200, 8'd3,   1'b1, 1'b1, 8'd3,   8'd1,   8'd50},
		'{DS_MASK_BLUE, 8'd255, 8'd255, 8'd255, 8'd4,   1'b0, 1'b1, 8'd63,  8'd63,  8'd255},
		'{DS_TINT_MAX,  8'd255, 8'd255, 8'd255, 8'd5,   1'b0, 1'b0, 8'd0,   8'd0,   8'd0},
		'{DS_TINT_MAX,  8'd1,   8'd1,   8'd1,   8'd6,   1'b0, 1'b0, 8'd0,   8'd0,   8'd0},
		'{DS_TINT_MAX,  8'd0,   8'd128, 8'd64,  8'd7,   1'b1, 1'b0, 8'd0,   8'd0,   8'd0},
		'{DS_TINT_MIN,  8'd255, 8'd255, 8'd255, 8'd8,   1'b0, 1'b0, 8'd0,   8'd0,   8'd0},
		'{DS_TINT_MIN,  8'd10,  8'd200, 8'd30,  8'd9,   1'b0, 1'b0, 8'd0,   8'd0,   8'd0},
		'{DS_TINT_MIX,  8'd100, 8'd100, 8'd100, 8'd10,  1'b0, 1'b0, 8'd0,   8'd0,   8'd0},
		'{DS_TINT_MIX,  8'd7,   8'd250, 8'd33,  8'd11,  1'b0, 1'b0, 8'd0,   8'd0,   8'd0},
		'{DS_TINT_MIX,  8'd0,   8'd1,   8'd2,   8'd12,  1'b1, 1'b0, 8'd0,   8'd0,   8'd0},
		'{DS_OFF_MAX,   8'd0,   8'd0,   8'd0,   8'd13,  1'b0, 1'b1, 8'd255, 8'd255, 8'd255},
		'{DS_OFF_MIN,   8'd255, 8'd255, 8'd255, 8'd14,  1'b0, 1'b1, 8'd0,   8'd0,   8'd0},
		'{DS_OFF_MIX,   8'd250, 8'd30,  8'd0,   8'd15,  1'b1, 1'b0, 8'd0,   8'd0,   8'd0},
		'{DS_FADE_ZERO, 8'd255, 8'd255, 8'd255, 8'd16,  1'b0, 1'b1, 8'd0,   8'd0,   8'd0},
		'{DS_FADE_HALF, 8'd255, 8'd1,   8'd100, 8'd17,  1'b0, 1'b0, 8'd0,   8'd0,   8'd0},
		'{DS_FADE_OVER, 8'd200, 8'd100, 8'd50,  8'd18,  1'b0, 1'b1, 8'd200, 8'd100, 8'd50},
		'{DS_FADE_MAX,  8'd255, 8'd0,   8'd128, 8'd19,  1'b1, 1'b0, 8'd0,   8'd0,   8'd0}
	};

	logic                  clk       = 1'b0;
	logic                  arst_n    = 1'b0;
	logic                  cfg_we    = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data  = '0;
	logic                  s_tvalid  = 1'b0;
	logic                  s_tready;
	logic [31:0]           s_tdata   = '0;   // red_in, green_in, blue_in, entry_index
	logic                  s_tlast   = 1'b0; // last_entry
	logic                  m_tvalid;
	logic                  m_tready  = 1'b0;
	logic [31:0]           m_tdata;          // red_out, green_out, blue_out, index_out
	logic                  m_tlast;          // last_out

	// bench copy of the settings registers, as the block should hold them
	logic [MASK_W-1:0] cur_mask;
	logic [TINT_W-1:0] cur_tint_r, cur_tint_g, cur_tint_b;
	logic [OFF_W-1:0]  cur_off_r, cur_off_g, cur_off_b;
	logic [FADE_W-1:0] cur_fade;

	entry_t pending_colors[$];   // recolored entries still owed by the block
	int     error_count  = 0;
	int     cycle_count  = 0;
	bit     tx_idle_en   = 1'b1;
	bit     rx_idle_en   = 1'b1;
	bit     hold_request = 1'b0;

	palette_color_effects dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tlast   (s_tlast),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast)
	);

	initial begin
		forever begin
			#10 clk = ~clk;
		end
	end

	// ------------------------------------------------------------------
	// Color model
	// ------------------------------------------------------------------

	function automatic longint clamp_channel(longint v);
		if (v < 0) begin
			return 0;
		end else if (v > 255) begin
			return 255;
		end
		return v;
	endfunction

	// Filter, tint, offset and fade for one channel. mul is the tint
	// multiplier with 13 fractional bits.
	function automatic logic [CH_W-1:0] recolor_channel(logic [CH_W-1:0] c_in, logic dim,
			longint mul, longint off);
		longint c;
		c = c_in;
		if (dim) begin
			c = c >> 2;
		end
		// integer division truncates toward zero, as the tint stage does
		c = clamp_channel(c + (c * mul + TINT_HALF) / TINT_DIV);
		c = clamp_channel(c + off);
		// fade only below one; everything from one up passes unchanged
		if (cur_fade < FADE_ONE) begin
			c = (c * longint'(cur_fade) + FADE_HALF) >> 16;
		end
		return c[CH_W-1:0];
	endfunction

	function automatic entry_t predict_colors(entry_t e);
		entry_t r;
		longint tr, tg, tb;
		logic   any_mask;
		tr       = $signed(cur_tint_r);
		tg       = $signed(cur_tint_g);
		tb       = $signed(cur_tint_b);
		any_mask = (cur_mask != '0);
		r.red    = recolor_channel(e.red,   any_mask && !cur_mask[0], 2*tr - tg - tb,
			$signed(cur_off_r));
		r.green  = recolor_channel(e.green, any_mask && !cur_mask[1], 2*tg - tr - tb,
			$signed(cur_off_g));
		r.blue   = recolor_channel(e.blue,  any_mask && !cur_mask[2], 2*tb - tr - tg,
			$signed(cur_off_b));
		r.index  = e.index;
		r.last   = e.last;
		return r;
	endfunction

	// ------------------------------------------------------------------
	// Settings writes
	// ------------------------------------------------------------------

	// Drive one register write, wait for the clock edge that takes it, then update the copy.
	// The value is cut to the register width, so stray high bits drop out.
	task automatic write_setting(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		case (idx)
			REG_FILTER_MASK:  cur_mask   = data[MASK_W-1:0];
			REG_TINT_RED:     cur_tint_r = data[TINT_W-1:0];
			REG_TINT_GREEN:   cur_tint_g = data[TINT_W-1:0];
			REG_TINT_BLUE:    cur_tint_b = data[TINT_W-1:0];
			REG_OFFSET_RED:   cur_off_r  = data[OFF_W-1:0];
			REG_OFFSET_GREEN: cur_off_g  = data[OFF_W-1:0];
			REG_OFFSET_BLUE:  cur_off_b  = data[OFF_W-1:0];
			REG_FADE_FACTOR:  cur_fade   = data[FADE_W-1:0];
			default: ;
		endcase
	endtask

	task automatic program_all(logic [CFG_DATA_W-1:0] mask_d,
			logic [CFG_DATA_W-1:0] tr_d, logic [CFG_DATA_W-1:0] tg_d,
			logic [CFG_DATA_W-1:0] tb_d, logic [CFG_DATA_W-1:0] or_d,
			logic [CFG_DATA_W-1:0] og_d, logic [CFG_DATA_W-1:0] ob_d,
			logic [CFG_DATA_W-1:0] fade_d);
		write_setting(REG_FILTER_MASK,  mask_d);
		write_setting(REG_TINT_RED,     tr_d);
		write_setting(REG_TINT_GREEN,   tg_d);
		write_setting(REG_TINT_BLUE,    tb_d);
		write_setting(REG_OFFSET_RED,   or_d);
		write_setting(REG_OFFSET_GREEN, og_d);
		write_setting(REG_OFFSET_BLUE,  ob_d);
		write_setting(REG_FADE_FACTOR,  fade_d);
		cfg_we <= 1'b0;
	endtask

	task automatic apply_preset(preset_e p);
		logic [CFG_DATA_W-1:0] mask_d, tr_d, tg_d, tb_d, or_d, og_d, ob_d, fade_d;
		mask_d = '0;
		tr_d   = '0;
		tg_d   = '0;
		tb_d   = '0;
		or_d   = '0;
		og_d   = '0;
		ob_d   = '0;
		fade_d = CFG_DATA_W'(FADE_ONE);
		case (p)
			DS_MASK_ALL:  mask_d = 17'd7;
			// upper bits beyond the mask width must be ignored
			DS_MASK_RED:  mask_d = 17'h1FFF9;
			DS_MASK_BLUE: mask_d = 17'd4;
			DS_TINT_MAX: begin
				tr_d = 17'(32767);
				tg_d = 17'(-32768);
				tb_d = 17'(-32768);
			end
			DS_TINT_MIN: begin
				tr_d = 17'(-32768);
				tg_d = 17'(32767);
				tb_d = 17'(32767);
			end
			DS_TINT_MIX: begin
				tr_d = {1'b1, 16'd4096};
				tg_d = 17'(-2048);
				tb_d = 17'(1234);
			end
			DS_OFF_MAX: begin
				or_d = 17'(1023);
				og_d = 17'(1023);
				ob_d = 17'(1023);
			end
			DS_OFF_MIN: begin
				or_d = 17'(-1024);
				og_d = 17'(-1024);
				ob_d = 17'(-1024);
			end
			DS_OFF_MIX: begin
				or_d = 17'(37);
				og_d = 17'(-37);
				ob_d = 17'(300);
			end
			DS_FADE_ZERO: fade_d = 17'd0;
			DS_FADE_HALF: fade_d = 17'd32768;
			DS_FADE_OVER: fade_d = 17'd131071;
			DS_FADE_MAX:  fade_d = 17'd65535;
			default: ;
		endcase
		program_all(mask_d, tr_d, tg_d, tb_d, or_d, og_d, ob_d, fade_d);
	endtask

	function automatic logic [CFG_DATA_W-1:0] pick_tint();
		int k;
		k = $urandom_range(0, 9);
		case (k)
			0, 1:    return '0;
			2:       return 17'(32767);
			3:       return 17'(-32768);
			8, 9:    return 17'($urandom);
			default: return 17'(int'($urandom_range(0, 8192)) - 4096);
		endcase
	endfunction

	function automatic logic [CFG_DATA_W-1:0] pick_offset();
		int k;
		k = $urandom_range(0, 9);
		case (k)
			0, 1, 2: return '0;
			3:       return 17'(1023);
			4:       return 17'(-1024);
			9:       return 17'($urandom);
			default: return 17'(int'($urandom_range(0, 128)) - 64);
		endcase
	endfunction

	function automatic logic [CFG_DATA_W-1:0] pick_fade();
		int k;
		k = $urandom_range(0, 9);
		case (k)
			0, 1, 2: return CFG_DATA_W'(FADE_ONE);
			3:       return '0;
			4:       return 17'd65535;
			5:       return 17'($urandom_range(65537, 131071));
			default: return 17'($urandom_range(0, 65535));
		endcase
	endfunction

	// ------------------------------------------------------------------
	// Input side
	// ------------------------------------------------------------------

	// Offer one entry, optionally after an idle gap, and hold it until the
	// transfer. The valid stays high afterwards so back-to-back entries
	// need no second assignment in one step.
	task automatic send_entry(entry_t e, logic typed, entry_t typed_colors);
		int gap;
		int k;
		gap = 0;
		if (tx_idle_en) begin
			k = $urandom_range(0, 99);
			if (k >= 95) begin
				gap = $urandom_range(8, 30);
			end else if (k >= 75) begin
				gap = $urandom_range(1, 3);
			end
		end
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {e.index, e.blue, e.green, e.red};
		s_tlast  <= e.last;
		do begin
			@(posedge clk);
		end while (!s_tready);
		pending_colors.push_back(typed ? typed_colors : predict_colors(e));
	endtask

	// Drop valid and wait until every owed result has come back.
	task automatic drain();
		s_tvalid <= 1'b0;
		while (pending_colors.size() != 0) begin
			@(posedge clk);
		end
	endtask

	function automatic logic [CH_W-1:0] pick_channel();
		int k;
		k = $urandom_range(0, 9);
		if (k == 0) begin
			return '0;
		end else if (k == 1) begin
			return '1;
		end
		return CH_W'($urandom);
	endfunction

	// ------------------------------------------------------------------
	// Output side: check each result transfer and pace tready
	// ------------------------------------------------------------------

	task automatic report_error(string msg);
		$display("ERROR at cycle %0d: %s", cycle_count, msg);
		error_count++;
	endtask

	task automatic check_field(string name, int got, int want, int idx);
		if (got != want) begin
			report_error($sformatf("entry %0d %s: got %0d, expected %0d", idx, name, got, want));
		end
	endtask

	initial begin
		entry_t want;
		int     stall_left;
		int     k;
		stall_left = 0;
		forever begin
			@(posedge clk);
			if (m_tvalid && m_tready) begin
				if (pending_colors.size() == 0) begin
					report_error($sformatf("result for entry %0d with nothing pending",
						m_tdata[31:24]));
				end else begin
					want = pending_colors.pop_front();
					check_field("red",   m_tdata[7:0],   want.red,   want.index);
					check_field("green", m_tdata[15:8],  want.green, want.index);
					check_field("blue",  m_tdata[23:16], want.blue,  want.index);
					check_field("index", m_tdata[31:24], want.index, want.index);
					check_field("last",  m_tlast,        want.last,  want.index);
				end
			end
			// Pace tready: a requested long hold wins, otherwise random stalls.
			if (stall_left > 0) begin
				stall_left--;
				m_tready <= 1'b0;
			end else if (hold_request) begin
				hold_request = 1'b0;
				stall_left   = HOLD_CYCLES - 1;
				m_tready    <= 1'b0;
			end else if (rx_idle_en && arst_n) begin
				k = $urandom_range(0, 99);
				if (k >= 95) begin
					stall_left = $urandom_range(10, 40) - 1;
					m_tready  <= 1'b0;
				end else if (k >= 70) begin
					stall_left = $urandom_range(1, 3) - 1;
					m_tready  <= 1'b0;
				end else begin
					m_tready <= 1'b1;
				end
			end else begin
				m_tready <= arst_n;
			end
		end
	end

	// ------------------------------------------------------------------
	// Run limit
	// ------------------------------------------------------------------

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("ERROR: run limit of %0d cycles reached", CYCLE_LIMIT);
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------

	initial begin
		preset_e current;
		entry_t  e;
		entry_t  typed_colors;
		int      sent;
		int      phase;
		int      n;

		// register copy follows the block's reset values
		cur_mask   = '0;
		cur_tint_r = '0;
		cur_tint_g = '0;
		cur_tint_b = '0;
		cur_off_r  = '0;
		cur_off_g  = '0;
		cur_off_b  = '0;
		cur_fade   = FADE_ONE;

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed table: rows sharing a preset form one phase. The first
		// phase runs on the reset values with no write at all.
		current = DS_RESET;
		for (int i = 0; i < DIR_ROWS; i++) begin
			if (directed_rows[i].preset != current) begin
				drain();
				current = directed_rows[i].preset;
				apply_preset(current);
			end
			e.red              = directed_rows[i].red;
			e.green            = directed_rows[i].green;
			e.blue             = directed_rows[i].blue;
			e.index            = directed_rows[i].index;
			e.last             = directed_rows[i].last;
			typed_colors       = e;
			typed_colors.red   = directed_rows[i].exp_red;
			typed_colors.green = directed_rows[i].exp_green;
			typed_colors.blue  = directed_rows[i].exp_blue;
			send_entry(e, directed_rows[i].typed, typed_colors);
		end
		drain();

		// Random phases: fresh settings, then a burst of random entries.
		sent  = 0;
		phase = 0;
		while (sent < RAND_ITEMS) begin
			program_all(($urandom_range(0, 1) != 0) ? 17'($urandom) : 17'($urandom_range(0, 7)),
				pick_tint(), pick_tint(), pick_tint(),
				pick_offset(), pick_offset(), pick_offset(), pick_fade());
			tx_idle_en = ($urandom_range(0, 3) != 0);
			rx_idle_en = ($urandom_range(0, 3) != 0);
			n = $urandom_range(20, 120);
			if (phase == PRESS_PHASE) begin
				// keep offering at full rate while the output holds off
				tx_idle_en   = 1'b0;
				hold_request = 1'b1;
				n            = 150;
			end
			for (int j = 0; j < n; j++) begin
				e.red   = pick_channel();
				e.green = pick_channel();
				e.blue  = pick_channel();
				e.index = CH_W'($urandom);
				e.last  = ($urandom_range(0, 7) == 0);
				send_entry(e, 1'b0, e);
			end
			sent += n;
			drain();
			phase++;
		end

		repeat (TAIL_CYCLES) @(posedge clk);
		if (error_count == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule

@@ files.f @@
rtl/pce_pkg.sv
rtl/pce_cfg.sv
rtl/pce_chan.sv
rtl/palette_color_effects.sv
tb/tb.sv
